@@ rtl/rfr_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the RTU frame receiver.
// No dependencies; imported by every module under rtl/ except rfr_fifo.
package rfr_pkg;

    localparam int CNT_W      = 9;
    localparam int MAXB_W     = 9;
    localparam int MINB_W     = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [MAXB_W-1:0] MAX_RESET = 9'd256;
    localparam logic [MINB_W-1:0] MIN_RESET = 4'd4;
    localparam logic [MINB_W-1:0] MIN_FLOOR = 4'd4;

    localparam int HDR_BYTES = 2;
    localparam int OVERHEAD  = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME = 8'd1;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] CMD_CRC   = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       frame_ok;
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [7:0] data_length;
    } t_out;

    typedef struct packed {
        logic [1:0]  code;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        logic [15:0] rx_crc;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [7:0]  data_length;
    } t_cmd;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/rfr_fifo.sv @@
// Two-entry register queue with independent push and pop.
// Depends on nothing; used between front and back and on the result side.
module rfr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/rfr_front.sv @@
// Front end: config registers, byte counting, header capture, CRC delay line.
// Turns accepted items into commands for the back end; some bytes give none. Uses rfr_pkg.
module rfr_front #(
    parameter int FRAME_LIMIT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_push,
    input  rfr_pkg::t_in                   i_item,
    input  logic                           i_cmd_full,
    output logic                           o_cmd_push,
    output rfr_pkg::t_cmd                  o_cmd
);
    import rfr_pkg::*;

    logic [MAXB_W-1:0] r_max;
    logic [MINB_W-1:0] r_min;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [7:0]        r_dly0, n_dly0;
    logic [7:0]        r_dly1, n_dly1;
    logic [7:0]        r_addr, n_addr;
    logic [7:0]        r_func, n_func;
    logic [CNT_W-1:0]  cap;
    logic [MINB_W-1:0] minlen;
    logic              accept;

    assign o_cfg_ready = 1'b1;
    assign cap    = (r_max > MAXB_W'(FRAME_LIMIT)) ? MAXB_W'(FRAME_LIMIT) : r_max;
    assign minlen = (r_min < MIN_FLOOR) ? MIN_FLOOR : r_min;
    assign accept = i_push && !i_cmd_full;

    always_comb begin
        n_count    = r_count;
        n_dly0     = r_dly0;
        n_dly1     = r_dly1;
        n_addr     = r_addr;
        n_func     = r_func;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (accept) begin
            if (i_item.operation == OP_BYTE) begin
                if (r_count < cap) begin
                    n_count = r_count + CNT_W'(1);
                    if (r_count == CNT_W'(0)) begin
                        n_addr          = i_item.rx_byte;
                        o_cmd_push      = 1'b1;
                        o_cmd.code      = CMD_CRC;
                        o_cmd.data_byte = i_item.rx_byte;
                    end else if (r_count == CNT_W'(1)) begin
                        n_func          = i_item.rx_byte;
                        o_cmd_push      = 1'b1;
                        o_cmd.code      = CMD_CRC;
                        o_cmd.data_byte = i_item.rx_byte;
                    end else begin
                        n_dly0 = r_dly1;
                        n_dly1 = i_item.rx_byte;
                        if (r_count >= CNT_W'(OVERHEAD)) begin
                            o_cmd_push       = 1'b1;
                            o_cmd.code       = CMD_DATA;
                            o_cmd.data_byte  = r_dly0;
                            o_cmd.data_index = 8'(r_count - CNT_W'(OVERHEAD));
                        end
                    end
                end
            end else begin
                o_cmd_push = 1'b1;
                if (r_count >= CNT_W'(minlen)) begin
                    o_cmd.code          = CMD_END;
                    o_cmd.rx_crc        = {r_dly1, r_dly0};
                    o_cmd.slave_address = r_addr;
                    o_cmd.function_code = r_func;
                    o_cmd.data_length   = 8'(r_count - CNT_W'(OVERHEAD));
                end else begin
                    o_cmd.code = CMD_CLEAR;
                end
                n_count = '0;
                n_dly0  = '0;
                n_dly1  = '0;
                n_addr  = '0;
                n_func  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_RESET;
            r_min   <= MIN_RESET;
            r_count <= '0;
            r_dly0  <= '0;
            r_dly1  <= '0;
            r_addr  <= '0;
            r_func  <= '0;
        end else begin
            r_count <= n_count;
            r_dly0  <= n_dly0;
            r_dly1  <= n_dly1;
            r_addr  <= n_addr;
            r_func  <= n_func;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_FRAME: r_max <= i_cfg_data[MAXB_W-1:0];
                    REG_MIN_FRAME: r_min <= i_cfg_data[MINB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ rtl/rfr_back.sv @@
// Back end: running CRC-16, frame check and result formatting.
// Consumes front commands, writes results to the output queue. Uses rfr_pkg.
module rfr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rfr_pkg::t_cmd i_cmd,
    input  logic          i_cmd_empty,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output rfr_pkg::t_out o_res
);
    import rfr_pkg::*;

    logic [15:0] r_crc, n_crc;
    logic        has_res;

    assign has_res   = (i_cmd.code == CMD_DATA) || (i_cmd.code == CMD_END);
    assign o_cmd_pop = !i_cmd_empty && (!has_res || !i_res_full);

    always_comb begin
        n_crc      = r_crc;
        o_res_push = 1'b0;
        o_res      = '0;
        if (o_cmd_pop) begin
            case (i_cmd.code)
                CMD_CRC: begin
                    n_crc = crc_update(r_crc, i_cmd.data_byte);
                end
                CMD_DATA: begin
                    n_crc            = crc_update(r_crc, i_cmd.data_byte);
                    o_res_push       = 1'b1;
                    o_res.kind       = KIND_DATA;
                    o_res.data_byte  = i_cmd.data_byte;
                    o_res.data_index = i_cmd.data_index;
                end
                CMD_END: begin
                    n_crc               = CRC_INIT;
                    o_res_push          = 1'b1;
                    o_res.kind          = KIND_END;
                    o_res.frame_ok      = (r_crc == i_cmd.rx_crc);
                    o_res.slave_address = i_cmd.slave_address;
                    o_res.function_code = i_cmd.function_code;
                    o_res.data_length   = i_cmd.data_length;
                end
                default: begin
                    n_crc = CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule

@@ rtl/rtu_frame_receiver_top.sv @@
// Top level of the RTU frame receiver: front end, command queue, back end, result queue.
// Depends on rfr_pkg, rfr_fifo, rfr_front and rfr_back.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------
//  input    | push / full               | i_item   (t_in)
//  result   | pop / empty               | o_result (t_out)
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle unless full; the front classifies in its accept cycle and the back
// applies one byte-wide CRC update per command, so the CRC update sets the clock path.
// A command is registered in the command queue, then its result in the result queue.
// Two-entry queues between front and back and on the result side absorb stalls.
// Synchronous active-low reset; config registers reset to 256 and 4.
module rtu_frame_receiver_top #(
    parameter int FRAME_LIMIT = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  rfr_pkg::t_in                   i_item,
    input  logic                           pop,
    output logic                           empty,
    output rfr_pkg::t_out                  o_result
);
    import rfr_pkg::*;

    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;
    t_cmd cmd_in;
    t_cmd cmd_out;
    logic res_push;
    logic res_full;
    t_out res_in;

    assign full = cmd_full;

    rfr_front #(
        .FRAME_LIMIT(FRAME_LIMIT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_item     (i_item),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    rfr_fifo #(
        .WIDTH($bits(t_cmd))
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (cmd_out),
        .o_empty(cmd_empty)
    );

    rfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_out),
        .i_cmd_empty(cmd_empty),
        .o_cmd_pop  (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    rfr_fifo #(
        .WIDTH($bits(t_out))
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (o_result),
        .o_empty(empty)
    );

endmodule
